// ----- rtl/ube_pkg.sv -----
// Package for the unicycle base and arm Euler step unit.
// Holds fixed-point constants, the CORDIC angle table, shared types and the saturating add.
// No dependencies.
package ube_pkg;

	localparam int DEF_NUM_JOINTS   = 7;
	localparam int DEF_FRAC_BITS    = 16;
	localparam int MAX_JOINT_FIELDS = 7;
	localparam int CORDIC_ITERS     = 20;
	localparam int ITER_W           = 5;
	localparam int PADDR_W          = 3;

	localparam logic [15:0] DT_RESET       = 16'd655;
	localparam logic [29:0] INV_TWO_PI     = 30'd683565276;
	localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
	localparam logic [31:0] CORDIC_GAIN_INV = 32'd652032874;

	// Register index decoded from paddr[2].
	localparam logic REG_DT_STEP = 1'b0;

	typedef enum logic {
		REQ_STEP = 1'b0,
		REQ_LOAD = 1'b1
	} req_type_t;

	typedef struct packed {
		logic               start;
		logic signed [31:0] z0;
	} cordic_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} cordic_rsp_t;

	function automatic logic signed [31:0] atan_lut(input logic [ITER_W-1:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0:    r = 32'sd843314857;
			5'd1:    r = 32'sd497837829;
			5'd2:    r = 32'sd263043837;
			5'd3:    r = 32'sd133525159;
			5'd4:    r = 32'sd67021687;
			5'd5:    r = 32'sd33543516;
			5'd6:    r = 32'sd16775851;
			5'd7:    r = 32'sd8388437;
			5'd8:    r = 32'sd4194283;
			5'd9:    r = 32'sd2097149;
			5'd10:   r = 32'sd1048576;
			5'd11:   r = 32'sd524288;
			5'd12:   r = 32'sd262144;
			5'd13:   r = 32'sd131072;
			5'd14:   r = 32'sd65536;
			5'd15:   r = 32'sd32768;
			5'd16:   r = 32'sd16384;
			5'd17:   r = 32'sd8192;
			5'd18:   r = 32'sd4096;
			5'd19:   r = 32'sd2048;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// Adds an increment to a 32-bit value and clamps to the signed 32-bit range.
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [51:0] inc);
		logic signed [52:0] s;
		logic signed [31:0] r;
		s = {{21{a[31]}}, a} + {inc[51], inc};
		if (s[52:31] == '0 || s[52:31] == '1) begin
			r = s[31:0];
		end else if (s[52]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

// ----- rtl/ube_if.sv -----
// Channel interfaces of the Euler step unit: request channel and result channel.
// Self-contained; valid/ready handshake with the payload fields as separate signals.
interface ube_in_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [31:0] base_a;
	logic signed [31:0] base_b;
	logic signed [31:0] base_c;
	logic signed [31:0] joint_in_0;
	logic signed [31:0] joint_in_1;
	logic signed [31:0] joint_in_2;
	logic signed [31:0] joint_in_3;
	logic signed [31:0] joint_in_4;
	logic signed [31:0] joint_in_5;
	logic signed [31:0] joint_in_6;

	modport source (output valid, req_type, base_a, base_b, base_c, joint_in_0, joint_in_1,
		joint_in_2, joint_in_3, joint_in_4, joint_in_5, joint_in_6, input ready);
	modport sink (input valid, req_type, base_a, base_b, base_c, joint_in_0, joint_in_1,
		joint_in_2, joint_in_3, joint_in_4, joint_in_5, joint_in_6, output ready);
endinterface

interface ube_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] heading_out;
	logic signed [31:0] joint_out_0;
	logic signed [31:0] joint_out_1;
	logic signed [31:0] joint_out_2;
	logic signed [31:0] joint_out_3;
	logic signed [31:0] joint_out_4;
	logic signed [31:0] joint_out_5;
	logic signed [31:0] joint_out_6;

	modport source (output valid, pos_x, pos_y, heading_out, joint_out_0, joint_out_1,
		joint_out_2, joint_out_3, joint_out_4, joint_out_5, joint_out_6, input ready);
	modport sink (input valid, pos_x, pos_y, heading_out, joint_out_0, joint_out_1,
		joint_out_2, joint_out_3, joint_out_4, joint_out_5, joint_out_6, output ready);
endinterface

// ----- rtl/ube_cordic.sv -----
// Iterative rotation-mode CORDIC producing cosine and sine in Q2.30, one iteration a cycle.
// Depends on ube_pkg for the angle table, gain constant and request/response types.
module ube_cordic
	import ube_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cordic_req_t req,
	output cordic_rsp_t rsp
);

	logic                    busy_q;
	logic                    done_q;
	logic [ITER_W-1:0]       iter_q;
	logic signed [31:0]      x_q;
	logic signed [31:0]      y_q;
	logic signed [31:0]      z_q;
	logic signed [31:0]      xs;
	logic signed [31:0]      ys;
	logic signed [31:0]      ang;

	assign xs  = x_q >>> iter_q;
	assign ys  = y_q >>> iter_q;
	assign ang = atan_lut(iter_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				if (iter_q == ITER_W'(CORDIC_ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= CORDIC_GAIN_INV;
			y_q <= '0;
			z_q <= req.z0;
		end else if (busy_q) begin
			if (!z_q[31]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.x    = x_q;
	assign rsp.y    = y_q;

endmodule

// ----- rtl/unicycle_base_arm_euler_step_unit.sv -----
// Forward-Euler step unit for a mobile base with an arm; top level with APB register port.
// Depends on ube_pkg, the ube_in_if/ube_out_if interfaces and ube_cordic.
//
// A load transaction's result is offered in the cycle after acceptance. A step transaction's
// result is formed in order after acceptance: two multiplies turn the heading into a
// quadrant and a Q2.30 angle, the CORDIC unit then runs 20 iterations, and a single shared
// 35x33 multiplier forms the base moves (two products per axis), the heading move and one
// joint move per cycle. The unit accepts one transaction at a time and is ready again in the
// cycle after the result has been taken. dt_step sits at byte address 0 and resets to 655.
module unicycle_base_arm_euler_step_unit
	import ube_pkg::*;
#(
	parameter int NUM_JOINTS = DEF_NUM_JOINTS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	ube_in_if.sink             in_ch,
	ube_out_if.source          out_ch
);

	localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_PH, S_RZ, S_CST, S_CRD, S_VC, S_VCT, S_VS, S_VST, S_HW, S_HJ, S_JN, S_OUT
	} state_t;

	state_t             state_q;
	logic [15:0]        dt_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [31:0] h_q;
	logic signed [31:0] jp_q [NUM_JOINTS];
	logic signed [31:0] jv_q [NUM_JOINTS];
	logic signed [31:0] v_q;
	logic signed [31:0] w_q;
	logic [1:0]         quad_q;
	logic [JW-1:0]      cnt_q;
	logic signed [67:0] prod_q;

	logic signed [31:0] in_joint [MAX_JOINT_FIELDS];
	logic signed [34:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [67:0] prod_d;
	logic signed [51:0] inc;
	logic signed [32:0] cs;
	logic signed [32:0] sn;
	logic [JW:0]        jsel;
	logic               in_acc;
	logic               cfg_wr;
	cordic_req_t        cor_req;
	cordic_rsp_t        cor_rsp;

	assign in_joint[0] = in_ch.joint_in_0;
	assign in_joint[1] = in_ch.joint_in_1;
	assign in_joint[2] = in_ch.joint_in_2;
	assign in_joint[3] = in_ch.joint_in_3;
	assign in_joint[4] = in_ch.joint_in_4;
	assign in_joint[5] = in_ch.joint_in_5;
	assign in_joint[6] = in_ch.joint_in_6;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DT_STEP);
	assign prdata = (paddr[2] == REG_DT_STEP) ? {16'd0, dt_q} : 32'd0;

	ube_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cor_req),
		.rsp    (cor_rsp)
	);

	assign cor_req.start = (state_q == S_CST);
	assign cor_req.z0    = prod_q[61:30];

	// Quadrant correction of the CORDIC result.
	always_comb begin
		unique case (quad_q)
			2'd0: begin
				cs = {cor_rsp.x[31], cor_rsp.x};
				sn = {cor_rsp.y[31], cor_rsp.y};
			end
			2'd1: begin
				cs = -{cor_rsp.y[31], cor_rsp.y};
				sn = {cor_rsp.x[31], cor_rsp.x};
			end
			2'd2: begin
				cs = -{cor_rsp.x[31], cor_rsp.x};
				sn = -{cor_rsp.y[31], cor_rsp.y};
			end
			default: begin
				cs = {cor_rsp.y[31], cor_rsp.y};
				sn = -{cor_rsp.x[31], cor_rsp.x};
			end
		endcase
	end

	assign jsel = (state_q == S_HJ) ? '0 : ({1'b0, cnt_q} + 1'b1);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_PH: begin
				mul_a = {{3{h_q[31]}}, h_q};
				mul_b = {3'd0, INV_TWO_PI};
			end
			S_RZ: begin
				mul_a = {5'd0, prod_q[FRAC_BITS+29:FRAC_BITS]};
				mul_b = {2'd0, HALF_PI_Q30};
			end
			S_VC: begin
				mul_a = {{3{v_q[31]}}, v_q};
				mul_b = cs;
			end
			S_VS: begin
				mul_a = {{3{v_q[31]}}, v_q};
				mul_b = sn;
			end
			S_VCT, S_VST: begin
				mul_a = prod_q[64:30];
				mul_b = {17'd0, dt_q};
			end
			S_HW: begin
				mul_a = {{3{w_q[31]}}, w_q};
				mul_b = {17'd0, dt_q};
			end
			S_HJ, S_JN: begin
				if (jsel < (JW+1)'(NUM_JOINTS)) begin
					mul_a = {{3{jv_q[jsel[JW-1:0]][31]}}, jv_q[jsel[JW-1:0]]};
				end
				mul_b = {17'd0, dt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;
	assign inc    = prod_q[67:16];

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (in_acc) begin
			v_q <= in_ch.base_a;
			w_q <= in_ch.base_b;
			for (int k = 0; k < NUM_JOINTS; k++) begin
				jv_q[k] <= in_joint[k];
			end
		end
		if (state_q == S_RZ) begin
			quad_q <= prod_q[FRAC_BITS+31:FRAC_BITS+30];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dt_q    <= DT_RESET;
			x_q     <= '0;
			y_q     <= '0;
			h_q     <= '0;
			cnt_q   <= '0;
			for (int k = 0; k < NUM_JOINTS; k++) begin
				jp_q[k] <= '0;
			end
		end else begin
			if (cfg_wr) begin
				dt_q <= pwdata[15:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_ch.req_type == REQ_LOAD) begin
							x_q <= in_ch.base_a;
							y_q <= in_ch.base_b;
							h_q <= in_ch.base_c;
							for (int k = 0; k < NUM_JOINTS; k++) begin
								jp_q[k] <= in_joint[k];
							end
							state_q <= S_OUT;
						end else begin
							state_q <= S_PH;
						end
					end
				end
				S_PH:  state_q <= S_RZ;
				S_RZ:  state_q <= S_CST;
				S_CST: state_q <= S_CRD;
				S_CRD: begin
					if (cor_rsp.done) begin
						state_q <= S_VC;
					end
				end
				S_VC:  state_q <= S_VCT;
				S_VCT: state_q <= S_VS;
				S_VS: begin
					x_q     <= sat_add(x_q, inc);
					state_q <= S_VST;
				end
				S_VST: state_q <= S_HW;
				S_HW: begin
					y_q     <= sat_add(y_q, inc);
					state_q <= S_HJ;
				end
				S_HJ: begin
					h_q     <= sat_add(h_q, inc);
					cnt_q   <= '0;
					state_q <= S_JN;
				end
				S_JN: begin
					jp_q[cnt_q] <= sat_add(jp_q[cnt_q], inc);
					cnt_q       <= cnt_q + 1'b1;
					if (cnt_q == JW'(NUM_JOINTS - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = (state_q == S_OUT);
	assign out_ch.pos_x       = x_q;
	assign out_ch.pos_y       = y_q;
	assign out_ch.heading_out = h_q;
	assign out_ch.joint_out_0 = jp_q[0];
	assign out_ch.joint_out_1 = (NUM_JOINTS > 1) ? jp_q[(NUM_JOINTS > 1) ? 1 : 0] : 32'sd0;
	assign out_ch.joint_out_2 = (NUM_JOINTS > 2) ? jp_q[(NUM_JOINTS > 2) ? 2 : 0] : 32'sd0;
	assign out_ch.joint_out_3 = (NUM_JOINTS > 3) ? jp_q[(NUM_JOINTS > 3) ? 3 : 0] : 32'sd0;
	assign out_ch.joint_out_4 = (NUM_JOINTS > 4) ? jp_q[(NUM_JOINTS > 4) ? 4 : 0] : 32'sd0;
	assign out_ch.joint_out_5 = (NUM_JOINTS > 5) ? jp_q[(NUM_JOINTS > 5) ? 5 : 0] : 32'sd0;
	assign out_ch.joint_out_6 = (NUM_JOINTS > 6) ? jp_q[(NUM_JOINTS > 6) ? 6 : 0] : 32'sd0;

endmodule
